@@ design/ps2mt_pkg.sv @@
// Package for the PS/2 mouse packet tracker.
// Holds the request, packet and result types, the framing phase type and the register codes.
// No dependencies.
package ps2mt_pkg;

  localparam int unsigned POS_W = 11;

  typedef struct packed {
    logic       aux_data;
    logic [7:0] data_byte;
  } ps2mt_req_t;

  typedef struct packed {
    logic [2:0]       buttons;
    logic [POS_W-1:0] x_position;
    logic [POS_W-1:0] y_position;
  } ps2mt_res_t;

  typedef struct packed {
    logic [2:0] buttons;
    logic       x_neg;
    logic       y_neg;
    logic [7:0] x_delta;
    logic [7:0] y_delta;
  } ps2mt_pkt_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_X      = 2'd1,
    PH_Y      = 2'd2
  } ps2mt_phase_t;

  typedef enum logic {
    CFG_X_LIMIT = 1'b0,
    CFG_Y_LIMIT = 1'b1
  } ps2mt_cfg_idx_t;

  localparam logic [POS_W-1:0] X_LIMIT_RST = 11'd79;
  localparam logic [POS_W-1:0] Y_LIMIT_RST = 11'd24;

  localparam int unsigned HDR_SYNC_BIT  = 3;
  localparam int unsigned HDR_X_NEG_BIT = 4;
  localparam int unsigned HDR_Y_NEG_BIT = 5;

endpackage

@@ design/ps2mt_fifo.sv @@
// Small register queue with push/full and pop/empty sides.
// Generic in width and depth; no package dependencies.
module ps2mt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ design/ps2mt_framer.sv @@
// Front part: keeps only auxiliary bytes and frames three-byte mouse packets.
// Depends on ps2mt_pkg.
module ps2mt_framer
  import ps2mt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req_valid,
  input  ps2mt_req_t req,
  output logic       pkt_push,
  output ps2mt_pkt_t pkt
);

  ps2mt_phase_t phase_r, phase_nxt;
  logic [7:0]   header_r, header_nxt;
  logic [7:0]   x_delta_r, x_delta_nxt;
  logic         take;

  assign take = req_valid && req.aux_data;

  always_comb begin
    phase_nxt   = phase_r;
    header_nxt  = header_r;
    x_delta_nxt = x_delta_r;
    if (take) begin
      unique case (phase_r)
        PH_X: begin
          x_delta_nxt = req.data_byte;
          phase_nxt   = PH_Y;
        end
        PH_Y: begin
          phase_nxt = PH_HEADER;
        end
        default: begin
          header_nxt = req.data_byte;
          phase_nxt  = req.data_byte[HDR_SYNC_BIT] ? PH_X : PH_HEADER;
        end
      endcase
    end
  end

  always_comb begin
    pkt_push    = take && (phase_r == PH_Y);
    pkt.buttons = header_r[2:0];
    pkt.x_neg   = header_r[HDR_X_NEG_BIT];
    pkt.y_neg   = header_r[HDR_Y_NEG_BIT];
    pkt.x_delta = x_delta_r;
    pkt.y_delta = req.data_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      header_r  <= '0;
      x_delta_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      header_r  <= header_nxt;
      x_delta_r <= x_delta_nxt;
    end
  end

endmodule

@@ design/ps2mt_tracker.sv @@
// Back part: holds the limits and position, applies packet deltas and clamps.
// Depends on ps2mt_pkg.
module ps2mt_tracker
  import ps2mt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  ps2mt_cfg_idx_t   cfg_index,
  input  logic [POS_W-1:0] cfg_data,
  input  logic             pkt_valid,
  input  ps2mt_pkt_t       pkt,
  output logic             res_push,
  output ps2mt_res_t       res
);

  logic [POS_W-1:0] x_limit_r, x_limit_nxt;
  logic [POS_W-1:0] y_limit_r, y_limit_nxt;
  logic [POS_W-1:0] x_pos_r, x_pos_nxt;
  logic [POS_W-1:0] y_pos_r, y_pos_nxt;
  logic [POS_W+1:0] x_sum, y_sum;

  always_comb begin
    x_limit_nxt = x_limit_r;
    y_limit_nxt = y_limit_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_X_LIMIT: x_limit_nxt = cfg_data;
        CFG_Y_LIMIT: y_limit_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    x_sum = {2'b00, x_pos_r} + {{(POS_W - 6){pkt.x_neg}}, pkt.x_delta};
    y_sum = {2'b00, y_pos_r} - {{(POS_W - 6){pkt.y_neg}}, pkt.y_delta};

    if (x_sum[POS_W+1]) begin
      x_pos_nxt = '0;
    end else if (x_sum[POS_W:0] > {1'b0, x_limit_r}) begin
      x_pos_nxt = x_limit_r;
    end else begin
      x_pos_nxt = x_sum[POS_W-1:0];
    end

    if (y_sum[POS_W+1]) begin
      y_pos_nxt = '0;
    end else if (y_sum[POS_W:0] > {1'b0, y_limit_r}) begin
      y_pos_nxt = y_limit_r;
    end else begin
      y_pos_nxt = y_sum[POS_W-1:0];
    end

    res_push       = pkt_valid;
    res.buttons    = pkt.buttons;
    res.x_position = x_pos_nxt;
    res.y_position = y_pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= X_LIMIT_RST;
      y_limit_r <= Y_LIMIT_RST;
      x_pos_r   <= '0;
      y_pos_r   <= '0;
    end else begin
      x_limit_r <= x_limit_nxt;
      y_limit_r <= y_limit_nxt;
      if (pkt_valid) begin
        x_pos_r <= x_pos_nxt;
        y_pos_r <= y_pos_nxt;
      end
    end
  end

endmodule

@@ design/ps2_mouse_packet_tracker.sv @@
// Top level of the PS/2 mouse packet tracker: framer, packet queue, tracker, result queue.
// Depends on ps2mt_pkg, ps2mt_fifo, ps2mt_framer and ps2mt_tracker.
//
//   Channel   Handshake        Payload
//   in_       in_push/in_full  in_data (aux_data, data_byte)
//   out_      out_pop/out_empty out_data (buttons, x_position, y_position)
//   cfg_      cfg_we           cfg_index, cfg_data
//
// One byte is accepted per cycle unless the packet queue is full. A result reaches
// the out_ ports by way of the packet queue, the tracker and the result queue.
// The framer writes whole packets into a small queue, and the tracker drains it
// whenever the result queue has room, so either side can stall independently.
// Reset is synchronous and clears framing, position and limits to their defaults.
module ps2_mouse_packet_tracker
  import ps2mt_pkg::*;
#(
  parameter int unsigned PKT_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  ps2mt_req_t     in_data,
  output logic           in_full,
  output logic           out_empty,
  input  logic           out_pop,
  output ps2mt_res_t     out_data,
  input  logic           cfg_we,
  input  ps2mt_cfg_idx_t cfg_index,
  input  logic [POS_W-1:0] cfg_data
);

  logic       pkt_push, pkt_full, pkt_empty, pkt_pop;
  ps2mt_pkt_t pkt_in, pkt_out;
  logic       res_push, res_full;
  ps2mt_res_t res;

  ps2mt_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_push && !in_full),
    .req       (in_data),
    .pkt_push  (pkt_push),
    .pkt       (pkt_in)
  );

  ps2mt_fifo #(
    .WIDTH ($bits(ps2mt_pkt_t)),
    .DEPTH (PKT_DEPTH)
  ) u_pkt_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (pkt_push),
    .wdata (pkt_in),
    .full  (pkt_full),
    .pop   (pkt_pop),
    .rdata (pkt_out),
    .empty (pkt_empty)
  );

  assign in_full = pkt_full;
  assign pkt_pop = !pkt_empty && !res_full;

  ps2mt_tracker u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pkt_valid (pkt_pop),
    .pkt       (pkt_out),
    .res_push  (res_push),
    .res       (res)
  );

  ps2mt_fifo #(
    .WIDTH ($bits(ps2mt_res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for ps2_mouse_packet_tracker: bytes and limits in, cursor results out.
// A predictor class tracks framing, position and limits and checks every popped result.
// Depends on ps2mt_pkg and the ps2_mouse_packet_tracker RTL.
module testbench;
  import ps2mt_pkg::*;

  class cursor_predictor;
    logic [POS_W-1:0] x_limit;
    logic [POS_W-1:0] y_limit;
    ps2mt_phase_t     phase;
    logic [7:0]       header;
    logic [7:0]       x_delta;
    logic [POS_W-1:0] x_pos;
    logic [POS_W-1:0] y_pos;
    ps2mt_res_t       expected_positions[$];
    int               errors;

    function new();
      x_limit = X_LIMIT_RST;
      y_limit = Y_LIMIT_RST;
      phase   = PH_HEADER;
      header  = '0;
      x_delta = '0;
      x_pos   = '0;
      y_pos   = '0;
      errors  = 0;
    endfunction

    function int pending();
      return expected_positions.size();
    endfunction

    function void write_limit(ps2mt_cfg_idx_t idx, logic [POS_W-1:0] value);
      case (idx)
        CFG_X_LIMIT: x_limit = value;
        CFG_Y_LIMIT: y_limit = value;
        default: ;
      endcase
    endfunction

    function logic [POS_W-1:0] clamp_to(int v, logic [POS_W-1:0] lim);
      if (v < 0) return '0;
      if (v > int'(lim)) return lim;
      return POS_W'(v);
    endfunction

    function void note_byte(ps2mt_req_t req);
      int dx;
      int dy;
      ps2mt_res_t res;
      if (!req.aux_data) return;
      case (phase)
        PH_X: begin
          x_delta = req.data_byte;
          phase   = PH_Y;
        end
        PH_Y: begin
          dx = int'(x_delta) - (header[HDR_X_NEG_BIT] ? 256 : 0);
          dy = int'(req.data_byte) - (header[HDR_Y_NEG_BIT] ? 256 : 0);
          x_pos = clamp_to(int'(x_pos) + dx, x_limit);
          y_pos = clamp_to(int'(y_pos) - dy, y_limit);
          res.buttons    = header[2:0];
          res.x_position = x_pos;
          res.y_position = y_pos;
          expected_positions.push_back(res);
          phase = PH_HEADER;
        end
        default: begin
          header = req.data_byte;
          phase  = header[HDR_SYNC_BIT] ? PH_X : PH_HEADER;
        end
      endcase
    endfunction

    function void check_position(ps2mt_res_t got);
      ps2mt_res_t want;
      if (expected_positions.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_positions.pop_front();
      if (got.buttons !== want.buttons) begin
        $display("%0t: buttons mismatch, expected %0d, actual %0d",
                 $time, want.buttons, got.buttons);
        errors++;
      end
      if (got.x_position !== want.x_position) begin
        $display("%0t: x_position mismatch, expected %0d, actual %0d",
                 $time, want.x_position, got.x_position);
        errors++;
      end
      if (got.y_position !== want.y_position) begin
        $display("%0t: y_position mismatch, expected %0d, actual %0d",
                 $time, want.y_position, got.y_position);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_push = 1'b0;
  ps2mt_req_t       in_data = '0;
  logic             in_full;
  logic             out_empty;
  logic             out_pop = 1'b0;
  ps2mt_res_t       out_data;
  logic             cfg_we = 1'b0;
  ps2mt_cfg_idx_t   cfg_index = CFG_X_LIMIT;
  logic [POS_W-1:0] cfg_data = '0;

  cursor_predictor tracker_model = new();
  bit              quiet = 1'b0;

  ps2_mouse_packet_tracker uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) tracker_model.write_limit(cfg_index, cfg_data);
      if (in_push && !in_full) tracker_model.note_byte(in_data);
      if (out_pop && !out_empty) tracker_model.check_position(out_data);
    end
  end

  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input bit aux, input logic [7:0] value);
    ps2mt_req_t req;
    req.aux_data  = aux;
    req.data_byte = value;
    in_push <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic maybe_idle(input int idle_pct);
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_positions_settled();
    in_push <= 1'b0;
    do @(posedge clk); while (tracker_model.pending() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limits(input logic [POS_W-1:0] x_lim, input logic [POS_W-1:0] y_lim);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_X_LIMIT;
    cfg_data  <= x_lim;
    @(posedge clk);
    cfg_index <= CFG_Y_LIMIT;
    cfg_data  <= y_lim;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_packets(input int count, input int xneg_pct, input int yneg_pct,
                              input int idle_pct);
    int         sent;
    int         roll;
    logic [7:0] header;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        send_byte(1'b0, 8'($urandom));
      end else if (roll < 10) begin
        send_byte(1'b1, 8'($urandom));
        sent++;
      end else if (roll == 10) begin
        wait_positions_settled();
      end else begin
        header = 8'($urandom);
        header[HDR_SYNC_BIT]  = 1'b1;
        header[HDR_X_NEG_BIT] = ($urandom_range(0, 99) < xneg_pct);
        header[HDR_Y_NEG_BIT] = ($urandom_range(0, 99) < yneg_pct);
        send_byte(1'b1, header);
        maybe_idle(idle_pct);
        if ($urandom_range(0, 19) == 0) send_byte(1'b0, 8'($urandom));
        send_byte(1'b1, 8'($urandom));
        maybe_idle(idle_pct);
        send_byte(1'b1, 8'($urandom));
        sent += 3;
      end
      maybe_idle(idle_pct);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(1'b0, 8'hFF);
    send_byte(1'b1, 8'hF7);
    send_byte(1'b1, 8'h08);
    send_byte(1'b0, 8'h55);
    send_byte(1'b1, 8'h7F);
    send_byte(1'b1, 8'h80);
    send_byte(1'b1, 8'hFF);
    send_byte(1'b1, 8'h80);
    send_byte(1'b1, 8'h7F);
    send_byte(1'b1, 8'h1D);
    send_byte(1'b1, 8'h00);
    send_byte(1'b1, 8'hFF);
    send_byte(1'b1, 8'h2A);
    send_byte(1'b1, 8'h01);
    send_byte(1'b1, 8'h00);
    send_byte(1'b1, 8'h08);
    send_byte(1'b1, 8'h00);
    send_byte(1'b1, 8'h00);
    wait_positions_settled();

    write_limits(11'd2047, 11'd2047);
    send_packets(300, 15, 85, 25);
    wait_positions_settled();

    write_limits(11'd5, 11'd3);
    send_byte(1'b1, 8'h08);
    send_byte(1'b1, 8'h00);
    send_byte(1'b1, 8'h00);
    send_packets(150, 50, 50, 40);
    wait_positions_settled();

    write_limits(11'd0, 11'd0);
    send_packets(100, 50, 50, 0);
    wait_positions_settled();

    write_limits(POS_W'($urandom), POS_W'($urandom));
    send_packets(250, 50, 50, 30);
    wait_positions_settled();

    write_limits(11'd2047, 11'd2047);
    send_packets(200, 85, 15, 20);
    wait_positions_settled();

    write_limits(POS_W'($urandom_range(0, 300)), POS_W'($urandom_range(0, 300)));
    quiet = 1'b1;
    send_packets(200, 50, 50, 0);
    wait_positions_settled();
    repeat (12) @(posedge clk);

    if (tracker_model.errors == 0 && tracker_model.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("status: fail");
    $finish;
  end

endmodule
